// File: hdl/ccc_pkg.sv
// ============================================================================
// ccc_pkg: shared types, constants and helpers of the calendar clock counter
// Field widths, rollover limits, digit position codes, set-control structs.
// ============================================================================
package ccc_pkg;

    localparam int unsigned UNIT_W  = 7;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned HI_W    = 8;
    localparam int unsigned TPS_W   = 16;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned POS_W   = 4;

    localparam logic [TPS_W-1:0] TPS_RESET = 16'd10;

    // roll over when the incremented value reaches the limit
    localparam logic [UNIT_W-1:0] SEC_LIMIT   = 7'd60;
    localparam logic [UNIT_W-1:0] MIN_LIMIT   = 7'd60;
    localparam logic [UNIT_W-1:0] HOUR_LIMIT  = 7'd24;
    localparam logic [UNIT_W-1:0] MONTH_LIMIT = 7'd13;

    localparam logic [UNIT_W-1:0] BASE_ZERO = 7'd0;
    localparam logic [UNIT_W-1:0] BASE_ONE  = 7'd1;

    // year register span in hundreds and remainder: 2^14 = 16384 = 163*100 + 84
    localparam logic [8:0] YEAR_WRAP_HI = 9'd163;
    localparam logic [7:0] YEAR_WRAP_LO = 8'd84;

    // digit position codes of a set item
    localparam logic [POS_W-1:0] POS_DAY_TENS       = 4'd1;
    localparam logic [POS_W-1:0] POS_DAY_UNITS      = 4'd2;
    localparam logic [POS_W-1:0] POS_MONTH_TENS     = 4'd3;
    localparam logic [POS_W-1:0] POS_MONTH_UNITS    = 4'd4;
    localparam logic [POS_W-1:0] POS_YEAR_THOUSANDS = 4'd5;
    localparam logic [POS_W-1:0] POS_YEAR_HUNDREDS  = 4'd6;
    localparam logic [POS_W-1:0] POS_YEAR_TENS      = 4'd7;
    localparam logic [POS_W-1:0] POS_YEAR_UNITS     = 4'd8;
    localparam logic [POS_W-1:0] POS_HOUR_TENS      = 4'd9;
    localparam logic [POS_W-1:0] POS_HOUR_UNITS     = 4'd10;
    localparam logic [POS_W-1:0] POS_MIN_TENS       = 4'd11;
    localparam logic [POS_W-1:0] POS_MIN_UNITS      = 4'd12;
    localparam logic [POS_W-1:0] POS_SEC_TENS       = 4'd13;
    localparam logic [POS_W-1:0] POS_SEC_UNITS      = 4'd14;

    typedef enum logic [1:0] {
        YP_THOUSANDS,
        YP_HUNDREDS,
        YP_TENS,
        YP_UNITS
    } t_year_place;

    typedef struct packed {
        logic               en;
        logic               tens;
        logic [DIGIT_W-1:0] digit;
    } t_set_ctrl;

    typedef struct packed {
        logic               en;
        t_year_place        place;
        logic [DIGIT_W-1:0] digit;
    } t_year_set;

    typedef struct packed {
        logic [3:0] tens;   // tens digit of (v mod 100)
        logic [3:0] units;  // v mod 10
    } t_digits;

    // Decimal digits of a 7-bit value: v/10 by reciprocal 205/2048 (exact below 128)
    function automatic t_digits split_digits(input logic [UNIT_W-1:0] v);
        logic [14:0] prod;
        logic [3:0]  q;
        t_digits     d;
        prod    = 15'(v) * 15'd205;
        q       = prod[14:11];
        d.units = 4'(v - 7'(q) * 7'd10);
        d.tens  = (q >= 4'd10) ? (q - 4'd10) : q;
        return d;
    endfunction

    // Month length; months outside 1..12 count 31 days
    function automatic logic [4:0] month_days(input logic [UNIT_W-1:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            7'd2: begin
                len = leap ? 5'd29 : 5'd28;
            end
            7'd4, 7'd6, 7'd9, 7'd11: begin
                len = 5'd30;
            end
            default: begin
                len = 5'd31;
            end
        endcase
        return len;
    endfunction

endpackage

// File: hdl/ccc_prescaler.sv
// ============================================================================
// ccc_prescaler: tick prescaler
// Counts ticks and flags the tick that completes a second.
// ============================================================================
module ccc_prescaler (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_tick,
    input  logic [ccc_pkg::TPS_W-1:0]  i_ticks_per_second,
    output logic                       o_second
);

    logic [ccc_pkg::TPS_W-1:0] r_count;
    logic [ccc_pkg::TPS_W-1:0] n_count;
    logic [ccc_pkg::TPS_W:0]   count_inc;

    always_comb begin
        count_inc = {1'b0, r_count} + 17'd1;
        o_second  = i_tick && (count_inc >= {1'b0, i_ticks_per_second});
        n_count   = r_count;
        if (i_tick) begin
            n_count = o_second ? '0 : count_inc[ccc_pkg::TPS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

// File: hdl/ccc_unit_cell.sv
// ============================================================================
// ccc_unit_cell: one 7-bit calendar unit
// Increments on carry in, rolls to base at the limit, or takes a digit set.
// ============================================================================
module ccc_unit_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [ccc_pkg::UNIT_W-1:0]  i_base,
    input  logic [ccc_pkg::UNIT_W-1:0]  i_limit,
    input  logic                        i_carry,
    input  ccc_pkg::t_set_ctrl          i_set,
    output logic [ccc_pkg::UNIT_W-1:0]  o_value,
    output logic                        o_carry
);

    logic [ccc_pkg::UNIT_W-1:0] r_value;
    logic [ccc_pkg::UNIT_W-1:0] n_value;
    logic [ccc_pkg::UNIT_W:0]   value_inc;
    logic [8:0]                 set_sum;
    ccc_pkg::t_digits           dg;

    always_comb begin
        value_inc = {1'b0, r_value} + 8'd1;
        dg        = ccc_pkg::split_digits(r_value);
        if (i_set.tens) begin
            set_sum = 9'(r_value) - 9'(dg.tens) * 9'd10 + 9'(i_set.digit) * 9'd10;
        end else begin
            set_sum = 9'(r_value) - 9'(dg.units) + 9'(i_set.digit);
        end

        n_value = r_value;
        o_carry = 1'b0;
        if (i_set.en) begin
            n_value = set_sum[ccc_pkg::UNIT_W-1:0];  // wraps to the register width
        end else if (i_carry) begin
            if (value_inc >= {1'b0, i_limit}) begin
                n_value = i_base;
                o_carry = 1'b1;
            end else begin
                n_value = value_inc[ccc_pkg::UNIT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= i_base;
        end else begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

// File: hdl/ccc_year_cell.sv
// ============================================================================
// ccc_year_cell: year held as hundreds and remainder (year = hi*100 + lo)
// Keeps decimal digits and leap test cheap; wraps after 9999 and at 14 bits.
// ============================================================================
module ccc_year_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_carry,
    input  ccc_pkg::t_year_set          i_set,
    output logic [ccc_pkg::YEAR_W-1:0]  o_year,
    output logic                        o_leap
);

    logic [ccc_pkg::HI_W-1:0]   r_hi;
    logic [ccc_pkg::UNIT_W-1:0] r_lo;
    logic [ccc_pkg::HI_W-1:0]   n_hi;
    logic [ccc_pkg::UNIT_W-1:0] n_lo;

    logic [ccc_pkg::UNIT_W-1:0] hi_mod;
    ccc_pkg::t_digits           dh;
    ccc_pkg::t_digits           dl;
    logic [8:0]                 hi_w;
    logic [8:0]                 hi_n;
    logic [8:0]                 hi_s;
    logic [7:0]                 lo_w;
    logic [7:0]                 lo_n;
    logic [7:0]                 lo_s;
    logic                       past_max;

    always_comb begin
        // digit set: replace one digit of (year mod 10000)
        hi_mod = (r_hi >= 8'd100) ? 7'(r_hi - 8'd100) : r_hi[ccc_pkg::UNIT_W-1:0];
        dh     = ccc_pkg::split_digits(hi_mod);
        dl     = ccc_pkg::split_digits(r_lo);
        hi_w   = 9'(r_hi);
        lo_w   = 8'(r_lo);
        case (i_set.place)
            ccc_pkg::YP_THOUSANDS: begin
                hi_w = 9'(r_hi) - 9'(dh.tens) * 9'd10 + 9'(i_set.digit) * 9'd10;
            end
            ccc_pkg::YP_HUNDREDS: begin
                hi_w = 9'(r_hi) - 9'(dh.units) + 9'(i_set.digit);
            end
            ccc_pkg::YP_TENS: begin
                lo_w = 8'(r_lo) - 8'(dl.tens) * 8'd10 + 8'(i_set.digit) * 8'd10;
            end
            ccc_pkg::YP_UNITS: begin
                lo_w = 8'(r_lo) - 8'(dl.units) + 8'(i_set.digit);
            end
            default: begin
            end
        endcase

        // bring lo back under 100
        if (lo_w >= 8'd100) begin
            lo_n = lo_w - 8'd100;
            hi_n = hi_w + 9'd1;
        end else begin
            lo_n = lo_w;
            hi_n = hi_w;
        end

        // truncate to 14 bits: subtract 16384 once when reached
        hi_s = hi_n;
        lo_s = lo_n;
        if ((hi_n > ccc_pkg::YEAR_WRAP_HI) ||
            ((hi_n == ccc_pkg::YEAR_WRAP_HI) && (lo_n >= ccc_pkg::YEAR_WRAP_LO))) begin
            if (lo_n >= ccc_pkg::YEAR_WRAP_LO) begin
                lo_s = lo_n - ccc_pkg::YEAR_WRAP_LO;
                hi_s = hi_n - ccc_pkg::YEAR_WRAP_HI;
            end else begin
                lo_s = lo_n + (8'd100 - ccc_pkg::YEAR_WRAP_LO);
                hi_s = hi_n - (ccc_pkg::YEAR_WRAP_HI + 9'd1);
            end
        end

        // year increment; anything at or past 9999 wraps to zero
        past_max = (r_hi >= 8'd100) || ((r_hi == 8'd99) && (r_lo == 7'd99));

        n_hi = r_hi;
        n_lo = r_lo;
        if (i_set.en) begin
            n_hi = hi_s[ccc_pkg::HI_W-1:0];
            n_lo = lo_s[ccc_pkg::UNIT_W-1:0];
        end else if (i_carry) begin
            if (past_max) begin
                n_hi = '0;
                n_lo = '0;
            end else if (r_lo == 7'd99) begin
                n_hi = r_hi + 8'd1;
                n_lo = '0;
            end else begin
                n_lo = r_lo + 7'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hi <= '0;
            r_lo <= '0;
        end else begin
            r_hi <= n_hi;
            r_lo <= n_lo;
        end
    end

    // divisible by 400 when lo is 0 and hi by 4; otherwise by 4 when lo is
    assign o_leap = (r_lo == 7'd0) ? (r_hi[1:0] == 2'b00) : (r_lo[1:0] == 2'b00);

    // hi*100 = hi*64 + hi*32 + hi*4
    assign o_year = ({6'b0, r_hi} << 6) + ({6'b0, r_hi} << 5) + ({6'b0, r_hi} << 2)
                  + {7'b0, r_lo};

endmodule

// File: hdl/calendar_clock_counter_unit.sv
// ============================================================================
// calendar_clock_counter_unit: real-time clock and Gregorian calendar
// The result of an item is on m_axis in the cycle after accept.
// Throughput: 1 item per cycle while m_axis drains; carries ripple combinationally.
// Reset (sync, active low): 00:00:00, day 1, month 1, year 0, 10 ticks/s.
// ============================================================================
module calendar_clock_counter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // ticks_per_second register
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,

    // request items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [3:0] digit_position, [7:4] digit_value
    input  logic        s_axis_tuser,   // req_type: 0 tick, 1 digit set

    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata    // [6:0] second_count, [13:7] minute_count,
                                        // [20:14] hour_count, [27:21] day_of_month,
                                        // [34:28] month_number, [48:35] year_number,
                                        // [49] second_strobe, [55:50] zero
);

    // ------------------------------------------------------------------
    // Structure: prescaler -> sec -> min -> hour -> day -> month -> year.
    // Each cell holds one unit and passes its rollover carry to the next
    // cell in the same cycle. The cell registers are the result register:
    // they change only when an item is accepted, and an item is accepted
    // whenever the result slot is empty or being drained, so a new item
    // goes in the same cycle the old result leaves.
    // ------------------------------------------------------------------

    logic [ccc_pkg::TPS_W-1:0]  r_ticks_per_second;
    logic                       r_out_valid;
    logic                       r_strobe;

    logic                       in_accept;
    logic                       tick;
    logic                       set_req;
    logic [ccc_pkg::POS_W-1:0]  digit_position;
    logic [ccc_pkg::DIGIT_W-1:0] digit_value;

    ccc_pkg::t_set_ctrl         set_sec;
    ccc_pkg::t_set_ctrl         set_min;
    ccc_pkg::t_set_ctrl         set_hour;
    ccc_pkg::t_set_ctrl         set_day;
    ccc_pkg::t_set_ctrl         set_month;
    ccc_pkg::t_year_set         set_year;

    logic                       second_done;
    logic                       carry_sec;
    logic                       carry_min;
    logic                       carry_hour;
    logic                       carry_day;
    logic                       carry_month;

    logic [ccc_pkg::UNIT_W-1:0] sec_val;
    logic [ccc_pkg::UNIT_W-1:0] min_val;
    logic [ccc_pkg::UNIT_W-1:0] hour_val;
    logic [ccc_pkg::UNIT_W-1:0] day_val;
    logic [ccc_pkg::UNIT_W-1:0] month_val;
    logic [ccc_pkg::YEAR_W-1:0] year_val;
    logic                       leap;
    logic [ccc_pkg::UNIT_W-1:0] day_limit;

    // handshake
    assign s_axis_tready  = !r_out_valid || m_axis_tready;
    assign in_accept      = s_axis_tvalid && s_axis_tready;
    assign tick           = in_accept && !s_axis_tuser;
    assign set_req        = in_accept && s_axis_tuser;
    assign digit_position = s_axis_tdata[3:0];
    assign digit_value    = s_axis_tdata[7:4];

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_second <= ccc_pkg::TPS_RESET;
        end else if (i_cfg_we) begin
            r_ticks_per_second <= i_cfg_wdata;
        end
    end

    // digit position decode; unused positions select no cell
    always_comb begin
        set_sec         = '{en: 1'b0, tens: 1'b0, digit: digit_value};
        set_min         = set_sec;
        set_hour        = set_sec;
        set_day         = set_sec;
        set_month       = set_sec;
        set_year.en     = 1'b0;
        set_year.place  = ccc_pkg::YP_UNITS;
        set_year.digit  = digit_value;
        case (digit_position)
            ccc_pkg::POS_DAY_TENS: begin
                set_day.en   = set_req;
                set_day.tens = 1'b1;
            end
            ccc_pkg::POS_DAY_UNITS: begin
                set_day.en   = set_req;
            end
            ccc_pkg::POS_MONTH_TENS: begin
                set_month.en   = set_req;
                set_month.tens = 1'b1;
            end
            ccc_pkg::POS_MONTH_UNITS: begin
                set_month.en   = set_req;
            end
            ccc_pkg::POS_YEAR_THOUSANDS: begin
                set_year.en    = set_req;
                set_year.place = ccc_pkg::YP_THOUSANDS;
            end
            ccc_pkg::POS_YEAR_HUNDREDS: begin
                set_year.en    = set_req;
                set_year.place = ccc_pkg::YP_HUNDREDS;
            end
            ccc_pkg::POS_YEAR_TENS: begin
                set_year.en    = set_req;
                set_year.place = ccc_pkg::YP_TENS;
            end
            ccc_pkg::POS_YEAR_UNITS: begin
                set_year.en    = set_req;
                set_year.place = ccc_pkg::YP_UNITS;
            end
            ccc_pkg::POS_HOUR_TENS: begin
                set_hour.en   = set_req;
                set_hour.tens = 1'b1;
            end
            ccc_pkg::POS_HOUR_UNITS: begin
                set_hour.en   = set_req;
            end
            ccc_pkg::POS_MIN_TENS: begin
                set_min.en   = set_req;
                set_min.tens = 1'b1;
            end
            ccc_pkg::POS_MIN_UNITS: begin
                set_min.en   = set_req;
            end
            ccc_pkg::POS_SEC_TENS: begin
                set_sec.en   = set_req;
                set_sec.tens = 1'b1;
            end
            ccc_pkg::POS_SEC_UNITS: begin
                set_sec.en   = set_req;
            end
            default: begin
            end
        endcase
    end

    // day rolls over once it passes the month length
    assign day_limit = 7'(ccc_pkg::month_days(month_val, leap)) + 7'd1;

    // cell chain
    ccc_prescaler u_prescaler (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_tick             (tick),
        .i_ticks_per_second (r_ticks_per_second),
        .o_second           (second_done)
    );

    ccc_unit_cell u_sec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_base  (ccc_pkg::BASE_ZERO),
        .i_limit (ccc_pkg::SEC_LIMIT),
        .i_carry (second_done),
        .i_set   (set_sec),
        .o_value (sec_val),
        .o_carry (carry_sec)
    );

    ccc_unit_cell u_min (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_base  (ccc_pkg::BASE_ZERO),
        .i_limit (ccc_pkg::MIN_LIMIT),
        .i_carry (carry_sec),
        .i_set   (set_min),
        .o_value (min_val),
        .o_carry (carry_min)
    );

    ccc_unit_cell u_hour (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_base  (ccc_pkg::BASE_ZERO),
        .i_limit (ccc_pkg::HOUR_LIMIT),
        .i_carry (carry_min),
        .i_set   (set_hour),
        .o_value (hour_val),
        .o_carry (carry_hour)
    );

    ccc_unit_cell u_day (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_base  (ccc_pkg::BASE_ONE),
        .i_limit (day_limit),
        .i_carry (carry_hour),
        .i_set   (set_day),
        .o_value (day_val),
        .o_carry (carry_day)
    );

    ccc_unit_cell u_month (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_base  (ccc_pkg::BASE_ONE),
        .i_limit (ccc_pkg::MONTH_LIMIT),
        .i_carry (carry_day),
        .i_set   (set_month),
        .o_value (month_val),
        .o_carry (carry_month)
    );

    ccc_year_cell u_year (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_carry (carry_month),
        .i_set   (set_year),
        .o_year  (year_val),
        .o_leap  (leap)
    );

    // result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            if (in_accept) begin
                r_out_valid <= 1'b1;
                r_strobe    <= second_done;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_strobe, year_val, month_val, day_val,
                            hour_val, min_val, sec_val};

`ifndef SYNTHESIS
    // a digit set never completes a second
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> !m_axis_tdata[49])
        else $error("second strobe raised by a set item");

    // every accepted item leaves a result behind
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
        else $error("accepted item produced no result");

    // date and time hold while no item is taken
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tvalid && s_axis_tready) |=> $stable(m_axis_tdata[48:0]))
        else $error("calendar changed without an accepted item");
`endif

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench: self-checking bench for calendar_clock_counter_unit
// Drives tick and digit-set items with random bursts and gaps, stalls the
// result side on shifting patterns, predicts every result with an in-bench
// calendar model and compares each result item field by field.
// ============================================================================
module testbench;

    import ccc_pkg::*;

    // request kinds carried on s_axis_tuser
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_SET  = 1'b1;

    // positions outside 1..14 leave every register alone
    localparam logic [POS_W-1:0] POS_UNUSED_LO = 4'd0;
    localparam logic [POS_W-1:0] POS_UNUSED_HI = 4'd15;

    localparam int unsigned YEAR_MAX    = 9999;
    localparam int unsigned UNIT_MASK   = (1 << UNIT_W) - 1;
    localparam int unsigned YEAR_MASK   = (1 << YEAR_W) - 1;
    localparam int unsigned LATENCY     = 1;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned LONG_STALL  = 400;

    typedef struct packed {
        logic               kind;
        logic [POS_W-1:0]   pos;
        logic [DIGIT_W-1:0] digit;
    } t_request;

    typedef struct packed {
        logic [UNIT_W-1:0] sec;
        logic [UNIT_W-1:0] min;
        logic [UNIT_W-1:0] hour;
        logic [UNIT_W-1:0] day;
        logic [UNIT_W-1:0] month;
        logic [YEAR_W-1:0] year;
        logic              strobe;
    } t_clock_reading;

    // ------------------------------------------------------------------------
    // DUT signals, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [15:0] i_cfg_wdata   = 16'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;   // [3:0] digit_position, [7:4] digit_value
    logic        s_axis_tuser  = 1'b0;   // req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;           // [6:0] sec, [13:7] min, [20:14] hour,
                                         // [27:21] day, [34:28] month,
                                         // [48:35] year, [49] second strobe

    calendar_clock_counter_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Calendar model state; reset happens once, so the reset values are
    // given right here. Wide ints on purpose: carries compare before masking.
    // ------------------------------------------------------------------------
    int unsigned cal_tps      = TPS_RESET;
    int unsigned cal_prescale = 0;
    int unsigned cal_sec      = BASE_ZERO;
    int unsigned cal_min      = BASE_ZERO;
    int unsigned cal_hour     = BASE_ZERO;
    int unsigned cal_day      = BASE_ONE;
    int unsigned cal_month    = BASE_ONE;
    int unsigned cal_year     = 0;

    t_request       pending_requests[$];   // items waiting for the driver
    t_clock_reading expected_dates[$];     // predicted results, oldest first

    int unsigned requests_queued   = 0;
    int unsigned requests_accepted = 0;
    int unsigned items_effective   = 0;    // queued items that change state
    int unsigned fail_count        = 0;
    int unsigned cycle_count       = 0;

    logic req_taken      = 1'b0;           // last posedge moved an item in
    logic sender_hold    = 1'b0;
    logic long_stall_req = 1'b0;

    // replace the digit of weight w (next weight span) in v
    function automatic int unsigned replace_digit(input int unsigned v, input int unsigned w,
                                                  input int unsigned span,
                                                  input int unsigned d);
        return v - ((v % span) - (v % w)) + d * w;
    endfunction

    // Advance the calendar model by one item and return the reading after it
    function automatic t_clock_reading clock_step(input t_request rq);
        t_clock_reading r;
        int unsigned    next_cnt;
        int unsigned    mlen;
        logic           leap;
        r.strobe = 1'b0;
        if (rq.kind == REQ_TICK) begin
            next_cnt = cal_prescale + 1;
            // reaching or passing the register ends the second, so a lowered
            // register ends it on the next tick
            if (next_cnt >= cal_tps) begin
                cal_prescale = 0;
                r.strobe     = 1'b1;
                cal_sec++;
                if (cal_sec >= SEC_LIMIT) begin
                    cal_sec = BASE_ZERO;
                    cal_min++;
                    if (cal_min >= MIN_LIMIT) begin
                        cal_min = BASE_ZERO;
                        cal_hour++;
                        if (cal_hour >= HOUR_LIMIT) begin
                            cal_hour = BASE_ZERO;
                            // Gregorian leap rule, year 0 counts as leap
                            leap = (cal_year % 400 == 0) ||
                                   ((cal_year % 4 == 0) && (cal_year % 100 != 0));
                            case (cal_month)
                                2: begin
                                    mlen = leap ? 29 : 28;
                                end
                                4, 6, 9, 11: begin
                                    mlen = 30;
                                end
                                default: begin
                                    mlen = 31;   // months outside 1..12 too
                                end
                            endcase
                            cal_day++;
                            if (cal_day > mlen) begin
                                cal_day = BASE_ONE;
                                cal_month++;
                                if (cal_month >= MONTH_LIMIT) begin
                                    cal_month = BASE_ONE;
                                    cal_year++;
                                    if (cal_year > YEAR_MAX) begin
                                        cal_year = 0;
                                    end
                                end
                            end
                        end
                    end
                end
            end else begin
                cal_prescale = next_cnt & 'hFFFF;
            end
        end else begin
            case (rq.pos)
                POS_DAY_TENS:       cal_day   = replace_digit(cal_day, 10, 100, rq.digit);
                POS_DAY_UNITS:      cal_day   = replace_digit(cal_day, 1, 10, rq.digit);
                POS_MONTH_TENS:     cal_month = replace_digit(cal_month, 10, 100, rq.digit);
                POS_MONTH_UNITS:    cal_month = replace_digit(cal_month, 1, 10, rq.digit);
                POS_YEAR_THOUSANDS: cal_year  = replace_digit(cal_year, 1000, 10000, rq.digit);
                POS_YEAR_HUNDREDS:  cal_year  = replace_digit(cal_year, 100, 1000, rq.digit);
                POS_YEAR_TENS:      cal_year  = replace_digit(cal_year, 10, 100, rq.digit);
                POS_YEAR_UNITS:     cal_year  = replace_digit(cal_year, 1, 10, rq.digit);
                POS_HOUR_TENS:      cal_hour  = replace_digit(cal_hour, 10, 100, rq.digit);
                POS_HOUR_UNITS:     cal_hour  = replace_digit(cal_hour, 1, 10, rq.digit);
                POS_MIN_TENS:       cal_min   = replace_digit(cal_min, 10, 100, rq.digit);
                POS_MIN_UNITS:      cal_min   = replace_digit(cal_min, 1, 10, rq.digit);
                POS_SEC_TENS:       cal_sec   = replace_digit(cal_sec, 10, 100, rq.digit);
                POS_SEC_UNITS:      cal_sec   = replace_digit(cal_sec, 1, 10, rq.digit);
                default: ;
            endcase
            // unchecked value, just truncated to register width
            cal_day   = cal_day & UNIT_MASK;
            cal_month = cal_month & UNIT_MASK;
            cal_year  = cal_year & YEAR_MASK;
            cal_hour  = cal_hour & UNIT_MASK;
            cal_min   = cal_min & UNIT_MASK;
            cal_sec   = cal_sec & UNIT_MASK;
        end
        r.sec   = cal_sec[UNIT_W-1:0];
        r.min   = cal_min[UNIT_W-1:0];
        r.hour  = cal_hour[UNIT_W-1:0];
        r.day   = cal_day[UNIT_W-1:0];
        r.month = cal_month[UNIT_W-1:0];
        r.year  = cal_year[YEAR_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void push_item(input logic kind, input int unsigned pos,
                                      input int unsigned digit);
        t_request rq;
        rq.kind  = kind;
        rq.pos   = pos[POS_W-1:0];
        rq.digit = digit[DIGIT_W-1:0];
        pending_requests.push_back(rq);
        requests_queued++;
        if (!(kind == REQ_SET && (rq.pos == POS_UNUSED_LO || rq.pos == POS_UNUSED_HI))) begin
            items_effective++;
        end
    endfunction

    // tens digit at pos_tens, units digit right after it
    function automatic void push_two_digits(input logic [POS_W-1:0] pos_tens,
                                            input int unsigned v);
        push_item(REQ_SET, pos_tens, v / 10);
        push_item(REQ_SET, pos_tens + 4'd1, v % 10);
    endfunction

    function automatic void push_year(input int unsigned yr);
        push_item(REQ_SET, POS_YEAR_THOUSANDS, yr / 1000);
        push_item(REQ_SET, POS_YEAR_HUNDREDS, (yr / 100) % 10);
        push_item(REQ_SET, POS_YEAR_TENS, (yr / 10) % 10);
        push_item(REQ_SET, POS_YEAR_UNITS, yr % 10);
    endfunction

    // Mostly: set a time close to midnight (often a month end and a year
    // with an interesting leap rule), then tick across the boundary.
    // The rest: raw noise and half-written settings.
    task automatic queue_calendar_traffic(input int unsigned n_items);
        int unsigned goal;
        int unsigned pick;
        int unsigned yr;
        int unsigned n_ticks;
        goal = items_effective + n_items;
        while (items_effective < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                if ($urandom_range(0, 9) < 6) begin
                    case ($urandom_range(0, 9))
                        0: yr = 0;
                        1: yr = 100;
                        2: yr = 400;
                        3: yr = 1900;
                        4: yr = 2000;
                        5: yr = 2023;
                        6: yr = 2024;
                        7: yr = 2100;
                        8: yr = YEAR_MAX;
                        default: yr = $urandom_range(0, YEAR_MAX);
                    endcase
                    push_year(yr);
                    push_two_digits(POS_MONTH_TENS, ($urandom_range(0, 99) < 85) ?
                                    $urandom_range(1, 12) : $urandom_range(0, 99));
                    push_two_digits(POS_DAY_TENS, ($urandom_range(0, 99) < 80) ?
                                    $urandom_range(28, 31) : $urandom_range(0, 99));
                end
                push_two_digits(POS_HOUR_TENS, ($urandom_range(0, 9) < 3) ?
                                $urandom_range(0, 23) : 23);
                push_two_digits(POS_MIN_TENS, ($urandom_range(0, 9) < 8) ?
                                59 : $urandom_range(0, 59));
                push_two_digits(POS_SEC_TENS, $urandom_range(55, 59));
                n_ticks = (cal_tps <= 4) ? $urandom_range(2, 12 * cal_tps)
                                         : $urandom_range(2, 40);
                repeat (n_ticks) begin
                    push_item(REQ_TICK, $urandom_range(0, 15), $urandom_range(0, 15));
                end
            end else if (pick < 85) begin
                push_item($urandom_range(0, 1), $urandom_range(0, 15), $urandom_range(0, 15));
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    push_item(REQ_SET, $urandom_range(POS_DAY_TENS, POS_SEC_UNITS),
                              $urandom_range(0, 9));
                end
                repeat ($urandom_range(1, 6)) begin
                    push_item(REQ_TICK, $urandom_range(0, 15), $urandom_range(0, 15));
                end
            end
        end
    endtask

    // every queued item accepted and every result back
    task automatic wait_drained;
        while (requests_accepted != requests_queued || expected_dates.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (LATENCY + 2) @(negedge i_clk);
    endtask

    // register write, only while the block is idle
    task automatic write_ticks_per_second(input logic [15:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        cal_tps = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Driver: bursts of random length, random gaps; item held until taken
    // ------------------------------------------------------------------------
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;

    always @(negedge i_clk) begin : drive_requests
        t_request rq;
        logic     offer;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!(s_axis_tvalid && !req_taken)) begin
            offer = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (!sender_hold && pending_requests.size() > 0) begin
                rq    = pending_requests.pop_front();
                offer = 1'b1;
                s_axis_tdata <= {rq.digit, rq.pos};
                s_axis_tuser <= rq.kind;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            s_axis_tvalid <= offer;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: one long stall on request, otherwise shifting ready patterns
    // ------------------------------------------------------------------------
    int unsigned stall_left   = 0;
    logic        stall_done   = 1'b0;
    int unsigned ready_mode   = 0;
    int unsigned mode_left    = 0;
    int unsigned ready_phase  = 0;

    always @(negedge i_clk) begin : drive_ready
        logic rdy;
        if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
        end else if (long_stall_req && !stall_done) begin
            // hold off long enough for the block to back up its input
            stall_left = LONG_STALL;
            stall_done = 1'b1;
            rdy        = 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(8, 80);
            end else begin
                mode_left--;
            end
            ready_phase++;
            case (ready_mode)
                0: rdy = 1'b1;
                1: rdy = $urandom_range(0, 1);
                2: rdy = ($urandom_range(0, 3) == 0);
                default: rdy = (ready_phase % 3 != 0);
            endcase
        end
        m_axis_tready <= rdy;
    end

    // ------------------------------------------------------------------------
    // Prediction at input acceptance
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : predict_on_accept
        t_request rq;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            rq.kind  = s_axis_tuser;
            rq.pos   = s_axis_tdata[3:0];
            rq.digit = s_axis_tdata[7:4];
            expected_dates.push_back(clock_step(rq));
            requests_accepted++;
        end
        req_taken <= s_axis_tvalid && s_axis_tready;
    end

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_clock_reading want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_dates.size() == 0) begin
                $error("result item with no expectation waiting");
                fail_count++;
            end else begin
                want = expected_dates.pop_front();
                check_field("second_count", want.sec, m_axis_tdata[6:0]);
                check_field("minute_count", want.min, m_axis_tdata[13:7]);
                check_field("hour_count", want.hour, m_axis_tdata[20:14]);
                check_field("day_of_month", want.day, m_axis_tdata[27:21]);
                check_field("month_number", want.month, m_axis_tdata[34:28]);
                check_field("year_number", want.year, m_axis_tdata[48:35]);
                check_field("second_strobe", want.strobe, m_axis_tdata[49]);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset rate of 10 ticks per second:
        // 9999-12-31 23:59:59 then one second wraps everything into year 0
        push_two_digits(POS_DAY_TENS, 31);
        push_two_digits(POS_MONTH_TENS, 12);
        push_year(YEAR_MAX);
        push_two_digits(POS_HOUR_TENS, 23);
        push_two_digits(POS_MIN_TENS, 59);
        push_two_digits(POS_SEC_TENS, 59);
        // unused positions leave the date alone
        push_item(REQ_SET, POS_UNUSED_LO, 15);
        push_item(REQ_SET, POS_UNUSED_HI, 9);
        repeat (10) push_item(REQ_TICK, 0, 0);
        // digit values above 9 and results past register width
        push_item(REQ_SET, POS_SEC_UNITS, 15);
        push_item(REQ_SET, POS_YEAR_THOUSANDS, 15);
        push_item(REQ_SET, POS_DAY_TENS, 15);
        queue_calendar_traffic(220);
        wait_drained();

        // one tick per second
        write_ticks_per_second(16'd1);
        queue_calendar_traffic(400);
        wait_drained();

        write_ticks_per_second(16'd2);
        queue_calendar_traffic(220);
        wait_drained();

        // slowest rate; the prescaler count left here exceeds the next setting
        write_ticks_per_second(16'hFFFF);
        queue_calendar_traffic(150);
        wait_drained();

        // long receiver hold-off while the sender keeps offering
        write_ticks_per_second(16'd3);
        queue_calendar_traffic(250);
        long_stall_req <= 1'b1;
        wait_drained();

        write_ticks_per_second(16'($urandom_range(4, 60)));
        queue_calendar_traffic(250);
        wait_drained();

        // sender pauses mid-phase until every result is back
        write_ticks_per_second(16'd1);
        queue_calendar_traffic(350);
        while (pending_requests.size() > 150) @(negedge i_clk);
        sender_hold <= 1'b1;
        @(negedge i_clk);
        while (s_axis_tvalid || expected_dates.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        sender_hold <= 1'b0;
        wait_drained();

        repeat (8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: calendar_clock_counter_unit.f
hdl/ccc_pkg.sv
hdl/ccc_prescaler.sv
hdl/ccc_unit_cell.sv
hdl/ccc_year_cell.sv
hdl/calendar_clock_counter_unit.sv
verif/testbench.sv
